/* design/particle_pool_update_unit_assert.svh */
// assertion macros used by the checker file
`ifndef PARTICLE_POOL_UPDATE_UNIT_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_UNIT_ASSERT_SVH

// a condition implies a consequence on the same clock edge
`define PPU_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// a condition implies a consequence on the next clock edge
`define PPU_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* design/ppu_pkg.sv */
// ----------------------------------------------------------------------------
// ppu_pkg
// shared types, constants and fixed-point helpers of the particle pool
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int NUM_PARTICLES = 1024;
    localparam int SLOT_W        = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int CNT_W         = $clog2(NUM_PARTICLES + 1);
    localparam int LIFE_W        = 17;
    localparam logic [LIFE_W-1:0] LIFE_FULL = 17'h10000;

    localparam logic [1:0] CFG_GRAVITY    = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP  = 2'd1;
    localparam logic [1:0] CFG_LIFE_DECAY = 2'd2;
    localparam logic [1:0] CFG_RISE_SPEED = 2'd3;

    localparam logic [31:0] GRAVITY_RESET    = 32'hFFD8_0000;
    localparam logic [15:0] TIME_STEP_RESET  = 16'd1092;
    localparam logic [15:0] LIFE_DECAY_RESET = 16'd33;
    localparam logic [31:0] RISE_SPEED_RESET = 32'd1966080;

    // controller to datapath commands
    typedef struct packed {
        logic              clr_en;      // clearing pass write
        logic              search_rd;   // read life at search index
        logic              read_rd;     // read one particle for mode 1
        logic              spawn_wr;    // write the spawn slot
        logic              upd_rd;      // read slot for update
        logic              spawn_take;  // capture spawn fields at accept
        logic              load_out;    // capture result registers
        logic              tick_out;    // result is a tick result
        logic              found;
        logic [SLOT_W-1:0] addr;        // index used for reads and clears
        logic [SLOT_W-1:0] spawn_slot;
    } ppu_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic life_zero;  // registered life at search index is zero
    } ppu_sts_t;

    // (v * t) >> 16 with floor, v signed 32, t unsigned 16
    function automatic logic [31:0] mul_dt(input logic signed [31:0] v,
                                           input logic [15:0] t);
        logic signed [48:0] p;
        begin
            p = v * $signed({1'b0, t});
            mul_dt = p[47:16];
        end
    endfunction

endpackage

/* design/particle_pool_update_unit.sv */
// ----------------------------------------------------------------------------
// particle_pool_update_unit
// particle pool with next-fit respawn and fixed-point euler update
// ----------------------------------------------------------------------------
// read beat: row read at accept, result registered in S_READ; next beat
//   the cycle after the result leaves
// tick beat: next-fit search of up to NUM_PARTICLES reads, one spawn write,
//   then an update sweep of every slot and a drain, set by the single read port
// after reset a clearing pass zeroes every slot of the pool; no beat is
//   taken until it ends, config writes are taken throughout
module particle_pool_update_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] spawn_x,
    input  logic [31:0] spawn_y,
    input  logic [31:0] spawn_z,
    input  logic [17:0] spawn_vx,
    input  logic [17:0] spawn_vz,
    input  logic [7:0]  spawn_color,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  spawned_slot,
    output logic        overridden,
    output logic        alive,
    output logic [16:0] life_left,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [31:0] vel_x,
    output logic [31:0] vel_y,
    output logic [31:0] vel_z,
    output logic [7:0]  color_level
);
    import ppu_pkg::*;

    ppu_cmd_t cmd;
    ppu_sts_t sts;
    logic     out_full;

    // result register doubles as the output valid
    assign out_valid = out_full;

    ppu_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_mode       (mode),
        .in_read_index (read_index),
        .out_full      (out_full),
        .cmd           (cmd),
        .sts           (sts)
    );

    ppu_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_read_index  (read_index),
        .in_spawn_x     (spawn_x),
        .in_spawn_y     (spawn_y),
        .in_spawn_z     (spawn_z),
        .in_spawn_vx    (spawn_vx),
        .in_spawn_vz    (spawn_vz),
        .in_spawn_color (spawn_color),
        .out_take       (out_full & ~out_stall),
        .out_full       (out_full),
        .spawned_slot   (spawned_slot),
        .overridden     (overridden),
        .alive          (alive),
        .life_left      (life_left),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .vel_z          (vel_z),
        .color_level    (color_level)
    );

endmodule

/* design/ppu_ctrl.sv */
// ----------------------------------------------------------------------------
// ppu_ctrl
// sequencer: clear pass, next-fit search, spawn, update sweep, result hand-off
// ----------------------------------------------------------------------------
module ppu_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                in_mode,
    input  logic [9:0]          in_read_index,
    input  logic                out_full,
    output ppu_pkg::ppu_cmd_t   cmd,
    input  ppu_pkg::ppu_sts_t   sts
);
    import ppu_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_SPAWN  = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_READ   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;      // steps done
    logic [SLOT_W-1:0] idx_reg, idx_next;      // walking slot index
    logic [SLOT_W-1:0] hint_reg, hint_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              found_reg, found_next;
    logic              chk_reg, chk_next;      // a search read is in flight
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic [2:0]        drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            hint_reg    <= '0;
            slot_reg    <= '0;
            found_reg   <= 1'b0;
            chk_reg     <= 1'b0;
            chk_idx_reg <= '0;
            drain_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            hint_reg    <= hint_next;
            slot_reg    <= slot_next;
            found_reg   <= found_next;
            chk_reg     <= chk_next;
            chk_idx_reg <= chk_idx_next;
            drain_reg   <= drain_next;
        end
    end

    function automatic logic [SLOT_W-1:0] inc_wrap(input logic [SLOT_W-1:0] a);
        begin
            if (a == SLOT_W'(NUM_PARTICLES - 1))
                inc_wrap = '0;
            else
                inc_wrap = a + 1'b1;
        end
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        hint_next    = hint_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        chk_next     = 1'b0;
        chk_idx_next = chk_idx_reg;
        drain_next   = drain_reg;
        in_stall     = 1'b1;
        cmd          = '0;
        cmd.addr       = idx_reg;
        cmd.spawn_slot = slot_reg;
        cmd.found      = found_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                idx_next   = inc_wrap(idx_reg);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_PARTICLES - 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                    idx_next   = '0;
                end
            end
            S_IDLE:
            begin
                in_stall = out_full;
                if (in_valid && !out_full)
                begin
                    if (in_mode)
                    begin
                        cmd.read_rd = 1'b1;
                        cmd.addr    = in_read_index[SLOT_W-1:0];
                        state_next  = S_READ;
                    end
                    else
                    begin
                        cmd.spawn_take = 1'b1;
                        state_next = S_SEARCH;
                        idx_next   = hint_reg;
                        cnt_next   = '0;
                        found_next = 1'b0;
                    end
                end
            end
            S_SEARCH:
            begin
                // one life read per cycle, result checked in the following cycle
                if (chk_reg && sts.life_zero)
                begin
                    found_next = 1'b1;
                    slot_next  = chk_idx_reg;
                    hint_next  = chk_idx_reg;
                    state_next = S_SPAWN;
                end
                else if (cnt_reg == CNT_W'(NUM_PARTICLES))
                begin
                    if (!chk_reg)
                    begin
                        found_next = 1'b0;
                        slot_next  = '0;
                        hint_next  = '0;
                        state_next = S_SPAWN;
                    end
                end
                else
                begin
                    cmd.search_rd = 1'b1;
                    chk_next      = 1'b1;
                    chk_idx_next  = idx_reg;
                    idx_next      = inc_wrap(idx_reg);
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            S_SPAWN:
            begin
                cmd.spawn_wr = 1'b1;
                state_next   = S_UPDATE;
                idx_next     = '0;
                cnt_next     = '0;
            end
            S_UPDATE:
            begin
                cmd.upd_rd = 1'b1;
                idx_next   = inc_wrap(idx_reg);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_PARTICLES - 1))
                begin
                    state_next = S_DRAIN;
                    drain_next = '0;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 3'd3)
                begin
                    cmd.load_out = 1'b1;
                    cmd.tick_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.load_out = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/ppu_datapath.sv */
// ----------------------------------------------------------------------------
// ppu_datapath
// particle memory, update pipeline, config registers and result registers
// ----------------------------------------------------------------------------
module ppu_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  ppu_pkg::ppu_cmd_t cmd,
    output ppu_pkg::ppu_sts_t sts,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [9:0]        in_read_index,
    input  logic [31:0]       in_spawn_x,
    input  logic [31:0]       in_spawn_y,
    input  logic [31:0]       in_spawn_z,
    input  logic [17:0]       in_spawn_vx,
    input  logic [17:0]       in_spawn_vz,
    input  logic [7:0]        in_spawn_color,
    input  logic              out_take,
    output logic              out_full,
    output logic [9:0]        spawned_slot,
    output logic              overridden,
    output logic              alive,
    output logic [16:0]       life_left,
    output logic [31:0]       pos_x,
    output logic [31:0]       pos_y,
    output logic [31:0]       pos_z,
    output logic [31:0]       vel_x,
    output logic [31:0]       vel_y,
    output logic [31:0]       vel_z,
    output logic [7:0]        color_level
);
    import ppu_pkg::*;

    localparam int ROW_W = LIFE_W + 8 + 6 * 32;

    // one row per particle: life, color, pos xyz, vel xyz
    logic [ROW_W-1:0]  mem [NUM_PARTICLES];
    logic [ROW_W-1:0]  rd_reg;
    logic              rd_ok_reg;
    logic              upd_v1_reg, upd_v2_reg;
    logic [SLOT_W-1:0] upd_a1_reg, upd_a2_reg;
    logic [SLOT_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic              wr_en;
    logic [31:0]       gravity_reg;
    logic [15:0]       time_step_reg, life_decay_reg;
    logic [31:0]       rise_speed_reg;
    logic [31:0]       g_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              rd_en;

    // spawn fields held from accept until the spawn write
    logic [31:0]       sp_x_reg, sp_y_reg, sp_z_reg;
    logic [17:0]       sp_vx_reg, sp_vz_reg;
    logic [7:0]        sp_color_reg;

    // stage two registers of the update
    logic [LIFE_W-1:0] s2_life_reg;
    logic [7:0]        s2_color_reg;
    logic [31:0]       s2_px_reg, s2_py_reg, s2_pz_reg;
    logic [31:0]       s2_vx_reg, s2_vy_reg, s2_vz_reg;

    logic [LIFE_W-1:0] l_rd, l_dec;
    logic [31:0]       vy_new;
    logic [31:0]       s2_vy_eff;
    logic [31:0]       dx, dy, dz;
    logic              s2_live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg    <= GRAVITY_RESET;
            time_step_reg  <= TIME_STEP_RESET;
            life_decay_reg <= LIFE_DECAY_RESET;
            rise_speed_reg <= RISE_SPEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRAVITY:    gravity_reg    <= cfg_data;
                CFG_TIME_STEP:  time_step_reg  <= cfg_data[15:0];
                CFG_LIFE_DECAY: life_decay_reg <= cfg_data[15:0];
                CFG_RISE_SPEED: rise_speed_reg <= cfg_data;
                default:        gravity_reg    <= gravity_reg;
            endcase
        end
    end

    // gravity step each cycle; user must keep config stable during a tick
    always_ff @(posedge clk)
    begin
        g_reg <= mul_dt(gravity_reg, time_step_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.spawn_take)
        begin
            sp_x_reg     <= in_spawn_x;
            sp_y_reg     <= in_spawn_y;
            sp_z_reg     <= in_spawn_z;
            sp_vx_reg    <= in_spawn_vx;
            sp_vz_reg    <= in_spawn_vz;
            sp_color_reg <= in_spawn_color;
        end
    end

    assign rd_en   = cmd.search_rd | cmd.read_rd | cmd.upd_rd;
    assign rd_addr = cmd.addr;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_v1_reg <= 1'b0;
            upd_v2_reg <= 1'b0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            upd_v1_reg <= cmd.upd_rd;
            upd_v2_reg <= upd_v1_reg;
            if (cmd.read_rd)
                rd_ok_reg <= ({1'b0, in_read_index} < 11'(NUM_PARTICLES));
        end
    end

    always_ff @(posedge clk)
    begin
        upd_a1_reg <= cmd.addr;
        upd_a2_reg <= upd_a1_reg;
    end

    assign sts.life_zero = (rd_reg[ROW_W-1 -: LIFE_W] == '0);

    // stage one: decay life and apply gravity to particles still alive
    assign l_rd   = rd_reg[ROW_W-1 -: LIFE_W];
    assign l_dec  = (l_rd > {1'b0, life_decay_reg}) ? l_rd - {1'b0, life_decay_reg} : '0;
    assign vy_new = rd_reg[63:32] + g_reg;

    always_ff @(posedge clk)
    begin
        s2_life_reg  <= l_dec;
        s2_color_reg <= rd_reg[ROW_W-LIFE_W-1 -: 8];
        s2_px_reg    <= rd_reg[191:160];
        s2_py_reg    <= rd_reg[159:128];
        s2_pz_reg    <= rd_reg[127:96];
        s2_vx_reg    <= rd_reg[95:64];
        s2_vy_reg    <= (l_dec != '0) ? vy_new : rd_reg[63:32];
        s2_vz_reg    <= rd_reg[31:0];
    end

    // stage two: move position of live particles by velocity times step
    assign s2_live   = (s2_life_reg != '0);
    assign s2_vy_eff = s2_vy_reg;
    assign dx = mul_dt(s2_vx_reg, time_step_reg);
    assign dy = mul_dt(s2_vy_eff, time_step_reg);
    assign dz = mul_dt(s2_vz_reg, time_step_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = upd_a2_reg;
        wr_data = '0;
        if (cmd.clr_en)
        begin
            wr_en   = 1'b1;
            wr_addr = cmd.addr;
        end
        else if (cmd.spawn_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = cmd.spawn_slot;
            wr_data = {LIFE_FULL, sp_color_reg, sp_x_reg, sp_y_reg, sp_z_reg,
                       {{14{sp_vx_reg[17]}}, sp_vx_reg}, rise_speed_reg,
                       {{14{sp_vz_reg[17]}}, sp_vz_reg}};
        end
        else if (upd_v2_reg)
        begin
            wr_en   = 1'b1;
            wr_data = {s2_life_reg, s2_color_reg,
                       s2_live ? s2_px_reg + dx : s2_px_reg,
                       s2_live ? s2_py_reg + dy : s2_py_reg,
                       s2_live ? s2_pz_reg + dz : s2_pz_reg,
                       s2_vx_reg, s2_vy_reg, s2_vz_reg};
        end
    end

    // result register, held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full <= 1'b0;
        else if (cmd.load_out)
            out_full <= 1'b1;
        else if (out_take)
            out_full <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.tick_out)
            begin
                spawned_slot <= 10'(cmd.spawn_slot);
                overridden   <= ~cmd.found;
                alive        <= 1'b0;
                life_left    <= '0;
                pos_x        <= '0;
                pos_y        <= '0;
                pos_z        <= '0;
                vel_x        <= '0;
                vel_y        <= '0;
                vel_z        <= '0;
                color_level  <= '0;
            end
            else
            begin
                spawned_slot <= '0;
                overridden   <= 1'b0;
                alive        <= rd_ok_reg && (l_rd != '0);
                life_left    <= rd_ok_reg ? l_rd : '0;
                color_level  <= rd_ok_reg ? rd_reg[ROW_W-LIFE_W-1 -: 8] : '0;
                pos_x        <= rd_ok_reg ? rd_reg[191:160] : '0;
                pos_y        <= rd_ok_reg ? rd_reg[159:128] : '0;
                pos_z        <= rd_ok_reg ? rd_reg[127:96] : '0;
                vel_x        <= rd_ok_reg ? rd_reg[95:64] : '0;
                vel_y        <= rd_ok_reg ? rd_reg[63:32] : '0;
                vel_z        <= rd_ok_reg ? rd_reg[31:0] : '0;
            end
        end
    end

endmodule

/* design/ppu_checker.sv */
// ----------------------------------------------------------------------------
// ppu_checker
// port-level checks of the particle pool
// ----------------------------------------------------------------------------
`include "particle_pool_update_unit_assert.svh"

module ppu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [9:0]  spawned_slot,
    input logic        overridden,
    input logic        alive,
    input logic [16:0] life_left
);
    `PPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(spawned_slot), "stalled result changed")
    `PPU_ASSERT_IMP(a_busy_stall, clk, rst_n, out_valid, in_stall, "beat taken while result waits")
    `PPU_ASSERT_IMP(a_override_slot0, clk, rst_n, out_valid && overridden, spawned_slot == 10'd0, "override did not take slot 0")
    `PPU_ASSERT_IMP(a_alive_life, clk, rst_n, out_valid && alive, life_left != 17'd0, "alive with no life")

endmodule

bind particle_pool_update_unit ppu_checker u_ppu_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .spawned_slot (spawned_slot),
    .overridden   (overridden),
    .alive        (alive),
    .life_left    (life_left)
);
